[hdl/assert_macros.svh]
// assertion macros used by the top rtl file of the key state table
// no dependencies; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked out of reset
`define KSTT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication, checked out of reset
`define KSTT_ASSERT_IMPL(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define KSTT_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[hdl/kstt_pkg.sv]
// types, codes and field layout for the key state table
// no dependencies
package kstt_pkg;

    // op codes as they arrive on the input beat
    localparam logic [2:0] OPC_TICK = 3'd0;
    localparam logic [2:0] OPC_DOWN = 3'd1;
    localparam logic [2:0] OPC_UP   = 3'd2;
    localparam logic [2:0] OPC_QKEY = 3'd3;
    localparam logic [2:0] OPC_QANY = 3'd4;

    // key states
    localparam logic [1:0] ST_NULL    = 2'd0;
    localparam logic [1:0] ST_PRESS   = 2'd1;
    localparam logic [1:0] ST_HOLD    = 2'd2;
    localparam logic [1:0] ST_RELEASE = 2'd3;

    // input beat layout
    localparam int OP_LSB     = 0;
    localparam int OP_W       = 3;
    localparam int KC_LSB     = 3;
    localparam int KEY_CODE_W = 8;
    localparam int QST_LSB    = 11;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 8;

    // internal probe ops, insert is the second pass of a key down
    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_DOWN   = 3'd1,
        OP_UP     = 3'd2,
        OP_QKEY   = 3'd3,
        OP_QANY   = 3'd4,
        OP_INSERT = 3'd5,
        OP_NONE   = 3'd6
    } op_t;

    // probe that walks the cell row
    typedef struct packed {
        logic       valid;
        op_t        op;
        logic [1:0] qst;
        logic       hit;
        logic       stop;
        logic [1:0] ks;
        logic       am;
    } probe_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_BUSY,
        FSM_FINISH
    } fsm_t;

    function automatic op_t decode_op(input logic [2:0] raw);
        op_t res;
        case (raw)
            OPC_TICK: res = OP_TICK;
            OPC_DOWN: res = OP_DOWN;
            OPC_UP:   res = OP_UP;
            OPC_QKEY: res = OP_QKEY;
            OPC_QANY: res = OP_QANY;
            default:  res = OP_NONE;
        endcase
        return res;
    endfunction

endpackage

[hdl/kstt_cell.sv]
// one table entry (code and state) with its stage of the probe row
// depends on kstt_pkg
module kstt_cell
    import kstt_pkg::*;
#(
    parameter int CODE_BITS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  probe_t               probe_in,
    input  logic [CODE_BITS-1:0] pcode_in,
    output probe_t               probe_out,
    output logic [CODE_BITS-1:0] pcode_out
);

    logic [CODE_BITS-1:0] code_reg, code_next;
    logic [1:0]           state_reg, state_next;
    probe_t               probe_reg, probe_next;
    logic [CODE_BITS-1:0] pcode_reg;
    logic                 code_match;

    assign code_match = (code_reg == pcode_in);

    always_comb
    begin
        code_next  = code_reg;
        state_next = state_reg;
        probe_next = probe_in;
        if (probe_in.valid)
        begin
            case (probe_in.op)
                OP_TICK:
                begin
                    if (state_reg == ST_RELEASE)
                    begin
                        state_next = ST_NULL;
                        code_next  = '0;
                    end
                    else if (state_reg == ST_PRESS)
                    begin
                        state_next = ST_HOLD;
                    end
                end
                OP_DOWN:
                begin
                    if (code_match)
                        probe_next.hit = 1'b1;
                end
                OP_UP:
                begin
                    if (!probe_in.hit && code_match)
                    begin
                        state_next     = ST_RELEASE;
                        probe_next.hit = 1'b1;
                    end
                end
                OP_QKEY:
                begin
                    if (!probe_in.hit && code_match)
                    begin
                        probe_next.hit = 1'b1;
                        probe_next.ks  = state_reg;
                    end
                end
                OP_QANY:
                begin
                    if (!probe_in.stop)
                    begin
                        if (code_reg == '0)
                            probe_next.stop = 1'b1;
                        else if (state_reg == probe_in.qst)
                        begin
                            probe_next.am   = 1'b1;
                            probe_next.stop = 1'b1;
                        end
                    end
                end
                OP_INSERT:
                begin
                    if (!probe_in.hit && state_reg == ST_NULL)
                    begin
                        state_next     = ST_PRESS;
                        code_next      = pcode_in;
                        probe_next.hit = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg  <= '0;
            state_reg <= ST_NULL;
            probe_reg <= '0;
        end
        else
        begin
            code_reg  <= code_next;
            state_reg <= state_next;
            probe_reg <= probe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pcode_reg <= pcode_in;
    end

    assign probe_out = probe_reg;
    assign pcode_out = pcode_reg;

endmodule

[hdl/key_state_tracker_table_unit.sv]
// the probe walks the whole cell row one cell per cycle for each accepted beat,
// twice for a key down of an unlisted code (search pass, then insert pass)
// a new beat is taken only after the result of the last one has gone to the output register,
// and the finish step waits while the output register still holds an untaken result
// reset: asynchronous active low, clears every entry to code 0 / null state at once
// a finished result waits in the output register while the next beat is taken
// top level of the key state table; depends on kstt_pkg, kstt_cell, assert_macros.svh
`include "assert_macros.svh"
module key_state_tracker_table_unit
    import kstt_pkg::*;
#(
    parameter int ENTRIES   = 64,
    parameter int CODE_BITS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // slave side: op [2:0], key_code [10:3], query_state [12:11], zero [15:13]
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // master side: key_state [1:0], any_match [2], zero [7:3]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    // sequencer state
    fsm_t                  state_reg, state_next;
    // code of the current item, reused by the insert pass
    logic [CODE_BITS-1:0]  code_reg, code_next;
    // result waiting for the output register
    logic [1:0]            res_ks_reg, res_ks_next;
    logic                  res_am_reg, res_am_next;
    // output register
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    // probe row: slot 0 is the launch point, slot ENTRIES is the exit
    probe_t                chain_ctl  [ENTRIES+1];
    logic [CODE_BITS-1:0]  chain_code [ENTRIES+1];
    probe_t                launch;
    logic [CODE_BITS-1:0]  launch_code;
    logic [CODE_BITS-1:0]  code_in;
    probe_t                exit_probe;

    // key code from the beat, fit to the table's code width
    genvar b;
    generate
        for (b = 0; b < CODE_BITS; b++)
        begin : g_code
            if (b < KEY_CODE_W)
            begin : g_bit
                assign code_in[b] = s_tdata[KC_LSB+b];
            end
            else
            begin : g_zero
                assign code_in[b] = 1'b0;
            end
        end
    endgenerate

    // the row of entry cells, each hands the probe on every cycle
    assign chain_ctl[0]  = launch;
    assign chain_code[0] = launch_code;

    genvar i;
    generate
        for (i = 0; i < ENTRIES; i++)
        begin : g_cell
            kstt_cell #(
                .CODE_BITS (CODE_BITS)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .probe_in  (chain_ctl[i]),
                .pcode_in  (chain_code[i]),
                .probe_out (chain_ctl[i+1]),
                .pcode_out (chain_code[i+1])
            );
        end
    endgenerate

    assign exit_probe = chain_ctl[ENTRIES];

    always_comb
    begin
        state_next   = state_reg;
        code_next    = code_reg;
        res_ks_next  = res_ks_reg;
        res_am_next  = res_am_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        launch       = '0;
        launch_code  = code_in;
        s_tready     = 1'b0;

        // output register drains independently of the sequencer
        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        case (state_reg)
            FSM_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    launch.valid = 1'b1;
                    launch.op    = decode_op(s_tdata[OP_LSB +: OP_W]);
                    launch.qst   = s_tdata[QST_LSB +: 2];
                    code_next    = code_in;
                    state_next   = FSM_BUSY;
                end
            end
            FSM_BUSY:
            begin
                if (exit_probe.valid)
                begin
                    if (exit_probe.op == OP_DOWN && !exit_probe.hit)
                    begin
                        // code not listed: second pass claims the first null entry
                        launch.valid = 1'b1;
                        launch.op    = OP_INSERT;
                        launch_code  = code_reg;
                    end
                    else
                    begin
                        res_ks_next = exit_probe.ks;
                        res_am_next = exit_probe.am;
                        state_next  = FSM_FINISH;
                    end
                end
            end
            FSM_FINISH:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{(OUT_DATA_W-3){1'b0}}, res_am_reg, res_ks_reg};
                    state_next   = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= FSM_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        code_reg   <= code_next;
        res_ks_reg <= res_ks_next;
        res_am_reg <= res_am_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // no probe may leave the row while the sequencer waits for a beat
    `KSTT_ASSERT_IMPL(a_idle_no_probe, state_reg == FSM_IDLE, !exit_probe.valid,
        "probe exits while idle")
    // an accepted beat always starts a scan
    `KSTT_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state_reg == FSM_BUSY,
        "accept did not start scan")
    // a new result beat only comes from the finish step
    `KSTT_ASSERT_IMPL(a_result_source, $rose(m_valid_reg), $past(state_reg == FSM_FINISH),
        "result without finish")
    // only key query and any query leave a nonzero result
    `KSTT_ASSERT_IMPL(a_result_zero,
        exit_probe.valid && exit_probe.op != OP_QKEY && exit_probe.op != OP_QANY,
        exit_probe.ks == ST_NULL && !exit_probe.am, "stray result bits")

endmodule
